FILE: hw/rtl/cla_pkg.sv
// Shared types and fixed constants for the cubic Lagrange resampler.
// Used by cla_mul, cla_interp and cubic_lagrange_resampler; depends on nothing.
`default_nettype none

package cla_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SPEED_W     = 19;
    localparam int FRAC_W      = 16;
    localparam int COUNT_W     = 5;
    localparam int MAX_RESULTS = 17;

    // Shared multiplier geometry: wide operand, narrow operand, full product.
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Weights are exact products scaled by 2^48, dropped by 2^24.
    localparam int WEIGHT_SHIFT = 24;
    localparam int ACC_W        = 48;

    // floor(m / 6) = (m * DIV6_RECIP) >> DIV6_SHIFT for m < 2^DIV6_IN_W.
    localparam int                  DIV6_IN_W  = 18;
    localparam logic [MUL_B_W-1:0]  DIV6_RECIP = 18'd174763;
    localparam int                  DIV6_SHIFT = 20;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [3:0][SAMPLE_W-1:0]   t_window;

    typedef struct packed {
        logic              start;
        logic [FRAC_W-1:0] frac;
    } t_interp_req;

    typedef struct packed {
        logic    done;
        t_sample value;
    } t_interp_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/cubic_lagrange_resampler.sv
// Top level of the four-point cubic Lagrange resampler: handshakes, window, phase, sequencer.
// Depends on cla_pkg; instantiates cla_interp (which holds the shared cla_mul).
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------
//  in       | to block  | i_in_valid / o_in_stall | i_source_sample
//  out      | from block| o_out_valid / i_out_stall| o_output_sample, o_last_of_run
//  cfg      | to block  | i_cfg_valid / o_cfg_ready| i_cfg_data (speed step, Q.16 frac)
//
// One input word at a time. A bypass word and the initial zero output skip cla_interp. Each
// interpolated output passes through the loop check, 14 steps in cla_interp (12 passes through
// the one shared 36x18 multiplier) and emit. At the slowest step 16 outputs follow one input.
// Reset (synchronous, active low) clears the window, phase, primed flag and sets the step
// to one. A stalled output word holds the sequencer in its emit state; nothing is dropped.
`default_nettype none

module cubic_lagrange_resampler #(
    parameter int PHASE_FRAC_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic signed [cla_pkg::SAMPLE_W-1:0]    i_source_sample,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [cla_pkg::SAMPLE_W-1:0]         o_output_sample,
    output logic                                        o_last_of_run,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [cla_pkg::SPEED_W-1:0]            i_cfg_data
);

    // Phase holds up to one sample plus the largest step (4.0): three integer bits.
    localparam int PW = PHASE_FRAC_BITS + 3;
    localparam int CW = (PW > cla_pkg::SPEED_W) ? PW : cla_pkg::SPEED_W;
    localparam int XW = PW + 7;
    localparam int NW = cla_pkg::COUNT_W;

    localparam logic [PW-1:0] PHASE_ONE = PW'(1) << PHASE_FRAC_BITS;
    localparam logic [CW-1:0] ONE_WIDE  = CW'(1) << PHASE_FRAC_BITS;
    localparam logic [CW-1:0] STEP_MIN  = CW'(1) << (PHASE_FRAC_BITS - 4);
    localparam logic [CW-1:0] STEP_MAX  = CW'(1) << (PHASE_FRAC_BITS + 2);
    localparam logic [XW-1:0] BYP_LO    = XW'(99) << PHASE_FRAC_BITS;
    localparam logic [XW-1:0] BYP_HI    = XW'(101) << PHASE_FRAC_BITS;
    localparam logic [cla_pkg::SPEED_W-1:0] SPEED_RESET = ONE_WIDE[cla_pkg::SPEED_W-1:0];
    localparam logic [NW-1:0] CNT_MAX   = NW'(cla_pkg::MAX_RESULTS);
    localparam logic [NW-1:0] CNT_LAST  = NW'(cla_pkg::MAX_RESULTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_CALC   = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [cla_pkg::SPEED_W-1:0]     r_speed_step, n_speed_step;
    logic [PW-1:0]                   r_phase, n_phase;
    logic                            r_primed, n_primed;
    cla_pkg::t_window                r_window, n_window;
    cla_pkg::t_sample                r_sample, n_sample;
    logic [NW-1:0]                   r_count, n_count;
    logic                            r_bypass, n_bypass;
    cla_pkg::t_sample                r_res_value, n_res_value;
    logic                            r_res_last, n_res_last;
    logic                            r_out_valid, n_out_valid;
    cla_pkg::t_sample                r_out_sample, n_out_sample;
    logic                            r_out_last, n_out_last;

    logic [CW-1:0]                   step_wide;
    logic [PW-1:0]                   step_c;
    logic [XW-1:0]                   step_x100;
    logic                            bypass;
    logic [PW-1:0]                   phase_next;
    logic [PHASE_FRAC_BITS+15:0]     frac_wide;
    logic                            out_free;
    cla_pkg::t_interp_req            interp_req;
    cla_pkg::t_interp_rsp            interp_rsp;

    // Clamp the step to [1/16, 4.0] before any use.
    assign step_wide = CW'(r_speed_step);
    always_comb begin
        if (step_wide < STEP_MIN) begin
            step_c = PW'(STEP_MIN);
        end else if (step_wide > STEP_MAX) begin
            step_c = PW'(STEP_MAX);
        end else begin
            step_c = PW'(step_wide);
        end
    end

    // Bypass band: step strictly inside (0.99, 1.01).
    assign step_x100  = XW'(step_c) * XW'(100);
    assign bypass     = (step_x100 > BYP_LO) && (step_x100 < BYP_HI);
    assign phase_next = r_phase + step_c;

    // Bring the phase fraction to 16 bits: truncate or zero-fill.
    assign frac_wide  = {r_phase[PHASE_FRAC_BITS-1:0], 16'b0} >> PHASE_FRAC_BITS;

    // Output register can take a word when empty or when its word leaves this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;

    cla_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (interp_req),
        .i_window (r_window),
        .o_rsp    (interp_rsp)
    );

    always_comb begin
        n_state        = r_state;
        n_speed_step   = r_speed_step;
        n_phase        = r_phase;
        n_primed       = r_primed;
        n_window       = r_window;
        n_sample       = r_sample;
        n_count        = r_count;
        n_bypass       = r_bypass;
        n_res_value    = r_res_value;
        n_res_last     = r_res_last;
        n_out_sample   = r_out_sample;
        n_out_last     = r_out_last;
        n_out_valid    = r_out_valid && i_out_stall;
        interp_req.start = 1'b0;
        interp_req.frac  = frac_wide[cla_pkg::FRAC_W-1:0];

        if (i_cfg_valid) begin
            n_speed_step = i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_sample = i_source_sample;
                    n_count  = '0;
                    n_bypass = bypass;
                    if (bypass) begin
                        // pass the sample straight through as its own last word
                        n_res_value = i_source_sample;
                        n_res_last  = 1'b1;
                        n_state     = ST_EMIT;
                    end else begin
                        n_state     = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (r_count != CNT_MAX && r_phase < PHASE_ONE) begin
                    n_res_last = (phase_next >= PHASE_ONE) || (r_count == CNT_LAST);
                    if (r_primed) begin
                        interp_req.start = 1'b1;
                        n_state          = ST_CALC;
                    end else begin
                        // first output after reset is zero
                        n_res_value = '0;
                        n_state     = ST_EMIT;
                    end
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_CALC: begin
                if (interp_rsp.done) begin
                    n_res_value = interp_rsp.value;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_res_value;
                    n_out_last   = r_res_last;
                    n_primed     = 1'b1;
                    if (r_bypass) begin
                        // shift the sample in, leave the phase alone
                        n_window = {r_sample, r_window[3:1]};
                        n_state  = ST_IDLE;
                    end else begin
                        n_phase  = phase_next;
                        n_count  = r_count + NW'(1);
                        n_state  = ST_CHECK;
                    end
                end
            end
            ST_FINISH: begin
                // shift the sample in and drop the phase by one sample
                n_window = {r_sample, r_window[3:1]};
                n_primed = 1'b1;
                n_phase  = (r_phase >= PHASE_ONE) ? (r_phase - PHASE_ONE) : '0;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_speed_step <= SPEED_RESET;
            r_phase      <= '0;
            r_primed     <= 1'b0;
            r_window     <= '0;
            r_count      <= '0;
            r_bypass     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_speed_step <= n_speed_step;
            r_phase      <= n_phase;
            r_primed     <= n_primed;
            r_window     <= n_window;
            r_count      <= n_count;
            r_bypass     <= n_bypass;
            r_out_valid  <= n_out_valid;
        end
        r_sample     <= n_sample;
        r_res_value  <= n_res_value;
        r_res_last   <= n_res_last;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_output_sample = r_out_sample;
    assign o_last_of_run   = r_out_last;

    // The run length never passes the guard.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("run counter beyond guard");

    // The interpolator is only ever busy on a phase inside the current interval.
    a_calc_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CALC) |-> (r_phase < PHASE_ONE))
        else $error("interpolation outside current interval");

    // A finished interpolation is only reported while the sequencer waits for it.
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        interp_rsp.done |-> (r_state == ST_CALC))
        else $error("interpolator result with no request pending");

    // A bypass word is always the last of its run.
    a_bypass_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_bypass) |-> r_res_last)
        else $error("bypass word not marked last");

endmodule

`default_nettype wire

FILE: hw/rtl/cla_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on cla_pkg for operand and product widths.
`default_nettype none

module cla_mul (
    input  wire logic                          i_clk,
    input  wire logic [cla_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic [cla_pkg::MUL_B_W-1:0]   i_b,
    output logic      [cla_pkg::MUL_P_W-1:0]   o_prod
);

    logic [cla_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= cla_pkg::MUL_P_W'(i_a) * cla_pkg::MUL_P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: hw/rtl/cla_interp.sv
// Microcoded cubic Lagrange evaluator: weights, weighted sum, divide by six, saturate.
// Depends on cla_pkg and instantiates cla_mul as its only arithmetic unit.
`default_nettype none

module cla_interp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire cla_pkg::t_interp_req  i_req,
    input  wire cla_pkg::t_window      i_window,
    output cla_pkg::t_interp_rsp       o_rsp
);

    typedef enum logic [14:0] {
        M_IDLE = 15'b000000000000001,
        M_BC   = 15'b000000000000010,
        M_BCD  = 15'b000000000000100,
        M_W0   = 15'b000000000001000,
        M_AC   = 15'b000000000010000,
        M_ACD  = 15'b000000000100000,
        M_W1   = 15'b000000001000000,
        M_AB   = 15'b000000010000000,
        M_ABD  = 15'b000000100000000,
        M_W2   = 15'b000001000000000,
        M_ABC  = 15'b000010000000000,
        M_W3   = 15'b000100000000000,
        M_ACC  = 15'b001000000000000,
        M_DIV  = 15'b010000000000000,
        M_OUT  = 15'b100000000000000
    } t_mstep;

    localparam int AW = cla_pkg::MUL_A_W;
    localparam int BW = cla_pkg::MUL_B_W;
    localparam int PW = cla_pkg::MUL_P_W;
    localparam int XW = cla_pkg::ACC_W;
    localparam int SW = cla_pkg::SAMPLE_W;
    localparam int WEIGHT_SHIFT_C = cla_pkg::WEIGHT_SHIFT;

    function automatic logic [SW-1:0] sample_mag(input logic [SW-1:0] s);
        sample_mag = s[SW-1] ? SW'(-s) : s;
    endfunction

    t_mstep                      r_mstep, n_mstep;
    logic [cla_pkg::FRAC_W-1:0]  r_frac, n_frac;
    logic [AW-1:0]               r_t, n_t;
    logic                        r_sign, n_sign;
    logic signed [XW-1:0]        r_acc, n_acc;
    logic                        r_neg, n_neg;
    logic                        r_sat, n_sat;

    logic [AW-1:0]  mul_a;
    logic [BW-1:0]  mul_b;
    logic [PW-1:0]  prod;

    logic [16:0]    a_op;
    logic [16:0]    cm;
    logic [17:0]    dm;
    logic [AW-1:0]  weight;
    logic [AW-1:0]  prod_x3;
    logic [XW-1:0]  term;
    logic [XW-1:0]  acc_mag;
    logic [XW-WEIGHT_SHIFT_C-1:0] m_val;
    logic [15:0]    quo;
    logic [SW-1:0]  result;

    cla_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Node distances: a = x, c = |x-2|, d = |x-3|, with x = 1 + frac.
    assign a_op    = 17'(r_frac) + 17'h10000;
    assign cm      = 17'h10000 - 17'(r_frac);
    assign dm      = 18'h20000 - 18'(r_frac);
    assign weight  = AW'(prod[PW-1:WEIGHT_SHIFT_C]);
    assign prod_x3 = prod[AW-1:0] + {prod[AW-2:0], 1'b0};
    assign term    = r_sign ? XW'(-prod[XW-1:0]) : prod[XW-1:0];
    assign acc_mag = r_acc[XW-1] ? XW'(-r_acc) : XW'(r_acc);
    assign m_val   = acc_mag[XW-1:WEIGHT_SHIFT_C];
    assign quo     = prod[cla_pkg::DIV6_SHIFT+15:cla_pkg::DIV6_SHIFT];

    always_comb begin
        if (r_neg) begin
            result = (r_sat || quo > 16'h8000) ? 16'h8000 : 16'(-quo);
        end else begin
            result = (r_sat || quo > 16'h7FFF) ? 16'h7FFF : quo;
        end
    end

    always_comb begin
        n_mstep = r_mstep;
        n_frac  = r_frac;
        n_t     = r_t;
        n_sign  = r_sign;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_sat   = r_sat;
        mul_a   = '0;
        mul_b   = '0;
        case (r_mstep)
            M_IDLE: begin
                if (i_req.start) begin
                    n_frac  = i_req.frac;
                    n_acc   = '0;
                    n_mstep = M_BC;
                end
            end
            M_BC: begin
                mul_a   = AW'(r_frac);
                mul_b   = BW'(cm);
                n_mstep = M_BCD;
            end
            M_BCD: begin
                mul_a   = prod[AW-1:0];
                mul_b   = dm;
                n_mstep = M_W0;
            end
            M_W0: begin
                // w0 is never positive
                mul_a   = weight;
                mul_b   = BW'(sample_mag(i_window[0]));
                n_sign  = ~i_window[0][SW-1];
                n_mstep = M_AC;
            end
            M_AC: begin
                n_acc   = r_acc + $signed(term);
                mul_a   = AW'(a_op);
                mul_b   = BW'(cm);
                n_mstep = M_ACD;
            end
            M_ACD: begin
                mul_a   = prod_x3;
                mul_b   = dm;
                n_mstep = M_W1;
            end
            M_W1: begin
                mul_a   = weight;
                mul_b   = BW'(sample_mag(i_window[1]));
                n_sign  = i_window[1][SW-1];
                n_mstep = M_AB;
            end
            M_AB: begin
                n_acc   = r_acc + $signed(term);
                mul_a   = AW'(a_op);
                mul_b   = BW'(r_frac);
                n_mstep = M_ABD;
            end
            M_ABD: begin
                // keep a*b for the last weight
                n_t     = prod[AW-1:0];
                mul_a   = prod_x3;
                mul_b   = dm;
                n_mstep = M_W2;
            end
            M_W2: begin
                mul_a   = weight;
                mul_b   = BW'(sample_mag(i_window[2]));
                n_sign  = i_window[2][SW-1];
                n_mstep = M_ABC;
            end
            M_ABC: begin
                n_acc   = r_acc + $signed(term);
                mul_a   = r_t;
                mul_b   = BW'(cm);
                n_mstep = M_W3;
            end
            M_W3: begin
                // w3 is never positive
                mul_a   = weight;
                mul_b   = BW'(sample_mag(i_window[3]));
                n_sign  = ~i_window[3][SW-1];
                n_mstep = M_ACC;
            end
            M_ACC: begin
                n_acc   = r_acc + $signed(term);
                n_mstep = M_DIV;
            end
            M_DIV: begin
                mul_a   = AW'(m_val[cla_pkg::DIV6_IN_W-1:0]);
                mul_b   = cla_pkg::DIV6_RECIP;
                n_neg   = r_acc[XW-1];
                n_sat   = (m_val >> cla_pkg::DIV6_IN_W) != '0;
                n_mstep = M_OUT;
            end
            M_OUT: begin
                n_mstep = M_IDLE;
            end
            default: begin
                n_mstep = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstep <= M_IDLE;
        end else begin
            r_mstep <= n_mstep;
        end
        r_frac <= n_frac;
        r_t    <= n_t;
        r_sign <= n_sign;
        r_acc  <= n_acc;
        r_neg  <= n_neg;
        r_sat  <= n_sat;
    end

    assign o_rsp.done  = (r_mstep == M_OUT);
    assign o_rsp.value = result;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for cubic_lagrange_resampler: directed and random source words
// checked against a cycle-free predictor of the window, phase and interpolator.
// Depends on cla_pkg and the resampler RTL.
module tb;

    localparam int              PHASE_FRAC_BITS = 16;
    localparam longint unsigned PHASE_ONE       = longint'(1) << PHASE_FRAC_BITS;
    localparam longint unsigned STEP_MIN        = PHASE_ONE >> 4;
    localparam longint unsigned STEP_MAX        = PHASE_ONE << 2;
    localparam longint          WEIGHT_ONE      = 65536;
    localparam longint          WEIGHT_DROP     = longint'(1) << 24;
    localparam int              SETTLE_CYCLES   = 400;
    localparam logic [cla_pkg::SPEED_W-1:0] STEP_ALL_ONES = '1;

    typedef struct {
        cla_pkg::t_sample sample;
        logic             last;
    } t_resampled_word;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic signed [cla_pkg::SAMPLE_W-1:0] i_source_sample;
    logic                o_out_valid;
    logic                i_out_stall;
    logic signed [cla_pkg::SAMPLE_W-1:0] o_output_sample;
    logic                o_last_of_run;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [cla_pkg::SPEED_W-1:0]  i_cfg_data;

    // Predictor state: window oldest first, phase ahead of the next source word.
    cla_pkg::t_sample    sample_win [4];
    longint unsigned     phase_acc;
    bit                  primed;
    logic [cla_pkg::SPEED_W-1:0]  speed_step;

    t_resampled_word     pending_words [$];
    int                  mismatch_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_request;
    int                  walk_level;

    cubic_lagrange_resampler #(
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_source_sample (i_source_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_output_sample (o_output_sample),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Cubic through the four held words at x = 1 + fraction of the phase.
    function automatic cla_pkg::t_sample lagrange_value(input longint unsigned ph);
        longint f, a, b, c, d;
        longint w0, w1, w2, w3, acc, q;
        f   = longint'((ph >> (PHASE_FRAC_BITS - 16)) & 64'hFFFF);
        a   = f + WEIGHT_ONE;
        b   = f;
        c   = f - WEIGHT_ONE;
        d   = f - 2 * WEIGHT_ONE;
        w0  = -(b * c * d) / WEIGHT_DROP;
        w1  = (3 * a * c * d) / WEIGHT_DROP;
        w2  = -(3 * a * b * d) / WEIGHT_DROP;
        w3  = (a * b * c) / WEIGHT_DROP;
        acc = longint'(sample_win[0]) * w0 + longint'(sample_win[1]) * w1
            + longint'(sample_win[2]) * w2 + longint'(sample_win[3]) * w3;
        q   = acc / (6 * WEIGHT_DROP);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return cla_pkg::t_sample'(q);
    endfunction

    // Queue every output word one accepted source word causes, then advance the state.
    task automatic resample_input(input cla_pkg::t_sample s);
        longint unsigned step;
        int              n;
        t_resampled_word w;
        step = longint'(speed_step);
        if (step < STEP_MIN)
            step = STEP_MIN;
        if (step > STEP_MAX)
            step = STEP_MAX;
        if (step * 100 > 99 * PHASE_ONE && step * 100 < 101 * PHASE_ONE) begin
            // Near unity: pass the word straight through, phase untouched.
            w.sample = s;
            w.last   = 1'b1;
            pending_words.push_back(w);
        end else begin
            n = 0;
            while (n < cla_pkg::MAX_RESULTS && phase_acc < PHASE_ONE) begin
                w.sample = primed ? lagrange_value(phase_acc) : cla_pkg::t_sample'(0);
                w.last   = 1'b0;
                pending_words.push_back(w);
                primed    = 1'b1;
                phase_acc = phase_acc + step;
                n++;
            end
            if (n > 0)
                pending_words[pending_words.size() - 1].last = 1'b1;
            if (phase_acc >= PHASE_ONE)
                phase_acc = phase_acc - PHASE_ONE;
            else
                phase_acc = 0;
        end
        sample_win[0] = sample_win[1];
        sample_win[1] = sample_win[2];
        sample_win[2] = sample_win[3];
        sample_win[3] = s;
        primed        = 1'b1;
    endtask

    // Offer one source word, idling at random first; hold it until accepted.
    task automatic send_word(input cla_pkg::t_sample s);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_source_sample <= s;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        resample_input(s);
    endtask

    // Drop valid, wait for every expected word, then let a silent input finish.
    task automatic wait_until_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_speed_step(input logic [cla_pkg::SPEED_W-1:0] value);
        wait_until_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        speed_step = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly a bounded random walk, with full-range words, silence and rails mixed in.
    function automatic cla_pkg::t_sample next_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            walk_level = walk_level + int'($urandom_range(4000)) - 2000;
            if (walk_level > 32767)
                walk_level = 32767;
            if (walk_level < -32768)
                walk_level = -32768;
            return cla_pkg::t_sample'(walk_level);
        end else if (pick < 85) begin
            return cla_pkg::t_sample'($urandom);
        end else if (pick < 90) begin
            return cla_pkg::t_sample'(0);
        end else if (pick < 95) begin
            return cla_pkg::t_sample'(32767);
        end else begin
            return cla_pkg::t_sample'(-32768);
        end
    endfunction

    // Receiver: honor a requested long hold-off first, else stall at random.
    initial begin : out_stall_gen
        int left;
        left        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                left         = hold_request;
                hold_request = 0;
            end
            if (left > 0) begin
                i_out_stall <= 1'b1;
                left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Compare each accepted output word with the oldest expectation.
    always @(posedge i_clk) begin : check_words
        t_resampled_word want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_words.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word: expected none, actual %0d last %b",
                         $time, o_output_sample, o_last_of_run);
            end else begin
                want = pending_words.pop_front();
                if (o_output_sample !== want.sample) begin
                    mismatch_count++;
                    $display("%0t: output_sample expected %0d actual %0d",
                             $time, want.sample, o_output_sample);
                end
                if (o_last_of_run !== want.last) begin
                    mismatch_count++;
                    $display("%0t: last_of_run expected %b actual %b",
                             $time, want.last, o_last_of_run);
                end
            end
        end
    end

    // Half-rate first: the very first output is the pending zero.
    task automatic test_first_output();
        write_speed_step(cla_pkg::SPEED_W'(32768));
        send_word(cla_pkg::t_sample'(32767));
        send_word(cla_pkg::t_sample'(-32768));
        send_word(cla_pkg::t_sample'(0));
    endtask

    // Push the cubic's overshoot past both rails.
    task automatic test_saturation();
        send_word(cla_pkg::t_sample'(-32768));
        send_word(cla_pkg::t_sample'(32767));
        send_word(cla_pkg::t_sample'(32767));
        send_word(cla_pkg::t_sample'(-32768));
        send_word(cla_pkg::t_sample'(32767));
        send_word(cla_pkg::t_sample'(-32768));
        send_word(cla_pkg::t_sample'(-32768));
        send_word(cla_pkg::t_sample'(32767));
        send_word(cla_pkg::t_sample'(1));
    endtask

    // Steps on and just outside the passthrough band.
    task automatic test_bypass_band();
        write_speed_step(cla_pkg::SPEED_W'(64880));
        send_word(cla_pkg::t_sample'(1234));
        send_word(cla_pkg::t_sample'(-4321));
        write_speed_step(cla_pkg::SPEED_W'(64881));
        send_word(cla_pkg::t_sample'(-1));
        write_speed_step(cla_pkg::SPEED_W'(65536));
        send_word(cla_pkg::t_sample'(21845));
        write_speed_step(cla_pkg::SPEED_W'(66191));
        send_word(cla_pkg::t_sample'(-21846));
        write_speed_step(cla_pkg::SPEED_W'(66192));
        send_word(cla_pkg::t_sample'(100));
        send_word(cla_pkg::t_sample'(-100));
    endtask

    // Register below the slowest and above the fastest usable step.
    task automatic test_step_clamp();
        write_speed_step(cla_pkg::SPEED_W'(0));
        send_word(cla_pkg::t_sample'(16384));
        send_word(cla_pkg::t_sample'(-16384));
        write_speed_step(STEP_ALL_ONES);
        send_word(cla_pkg::t_sample'(30000));
        send_word(cla_pkg::t_sample'(-30000));
        send_word(cla_pkg::t_sample'(7));
        send_word(cla_pkg::t_sample'(-7));
    endtask

    // Hold the output off long enough to back the block up, then drain and resume.
    task automatic test_backpressure();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_speed_step(cla_pkg::SPEED_W'(16384));
        @(posedge i_clk);
        hold_request = 400;
        for (k = 0; k < 12; k++)
            send_word(next_sample());
        wait_until_idle();
        for (k = 0; k < 4; k++)
            send_word(next_sample());
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int                          seg;
        int                          k;
        logic [cla_pkg::SPEED_W-1:0] step;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (seg = 0; seg < 5; seg++) begin
            case ($urandom_range(9))
                0:       step = cla_pkg::SPEED_W'($urandom_range(16384, 4096));
                1:       step = cla_pkg::SPEED_W'($urandom_range(66191, 64881));
                2:       step = cla_pkg::SPEED_W'($urandom);
                3, 4:    step = cla_pkg::SPEED_W'($urandom_range(98304, 49152));
                default: step = cla_pkg::SPEED_W'($urandom_range(262144, 16384));
            endcase
            write_speed_step(step);
            for (k = 0; k < 18; k++)
                send_word(next_sample());
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_source_sample = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_request    = 0;
        walk_level      = 0;
        sample_win      = '{default: '0};
        phase_acc       = 0;
        primed          = 1'b0;
        speed_step      = cla_pkg::SPEED_W'(PHASE_ONE);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_output();
        test_saturation();
        test_bypass_band();
        test_step_clamp();
        test_backpressure();
        test_random_traffic(30, 67);
        test_random_traffic(67, 30);
        test_random_traffic(0, 0);

        wait_until_idle();
        if (mismatch_count == 0 && pending_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
